[hw/rtl/tsp_pkg.sv]
// Package for the twinkle star pool engine: payload types, config types and state codes.
`timescale 1ns / 1ps
package tsp_pkg;

  // Configuration register indexes
  localparam logic [2:0] RegSpawnMode   = 3'd0;
  localparam logic [2:0] RegChance      = 3'd1;
  localparam logic [2:0] RegPeakLevel   = 3'd2;
  localparam logic [2:0] RegFadeInRate  = 3'd3;
  localparam logic [2:0] RegFadeOutRate = 3'd4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // One tick transaction as it arrives
  typedef struct packed {
    logic [7:0]  tick_ms;
    logic [9:0]  chance_roll;
    logic [9:0]  led_draw;
    logic [15:0] duration_draw;
    logic [15:0] gap_draw;
    logic [7:0]  draw_red;
    logic [7:0]  draw_green;
    logic [7:0]  draw_blue;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic        pixel_valid;
    logic [9:0]  led_index;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        last_pixel;
  } res_t;

  // Tick after the front has classified it
  typedef struct packed {
    logic [7:0]  tick_ms;
    logic [9:0]  chance_roll;
    logic [9:0]  led;
    logic [15:0] duration;
    logic [15:0] gap;
    logic [23:0] colour;
  } work_t;

  // Configuration registers as seen by the back end
  typedef struct packed {
    logic        spawn_mode;
    logic [9:0]  chance_permille;
    logic [15:0] peak_level;
    logic [15:0] fade_in_rate;
    logic [15:0] fade_out_rate;
  } cfg_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SPAWN,
    ST_EMIT,
    ST_NONE
  } back_state_e;

endpackage

[hw/rtl/tsp_front.sv]
// Front end: accepts tick transactions, clamps the LED draw, queues them for the back end.
`timescale 1ns / 1ps
module tsp_front #(
  parameter int unsigned LED_COUNT = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tsp_pkg::in_item_t item_i,
  output logic              full_o,
  input  logic              take_i,
  output logic              avail_o,
  output tsp_pkg::work_t    work_o
);
  import tsp_pkg::*;

  localparam logic [16:0] LedMax = 17'(LED_COUNT - 1);

  work_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wen, ren;
  work_t      cls;

  // Classify: clamp LED position, pack colour
  always_comb begin
    cls.tick_ms     = item_i.tick_ms;
    cls.chance_roll = item_i.chance_roll;
    cls.led         = ({7'd0, item_i.led_draw} > LedMax) ? LedMax[9:0] : item_i.led_draw;
    cls.duration    = item_i.duration_draw;
    cls.gap         = item_i.gap_draw;
    cls.colour      = {item_i.draw_red, item_i.draw_green, item_i.draw_blue};
  end

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign work_o  = mem_q[rd_q];
  assign wen     = push_i && !full_o;
  assign ren     = take_i && avail_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_d  = wen ? ~wr_q : wr_q;
    rd_d  = ren ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(wen) - 2'(ren);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[wr_q] <= cls;
    end
  end

endmodule

[hw/rtl/tsp_res_fifo.sv]
// Result queue: two-entry FIFO that holds finished pixel transactions.
`timescale 1ns / 1ps
module tsp_res_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  tsp_pkg::res_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tsp_pkg::res_t data_o
);
  import tsp_pkg::*;

  res_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wen, ren;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];
  assign wen     = wr_i && !full_o;
  assign ren     = pop_i && !empty_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_d  = wen ? ~wr_q : wr_q;
    rd_d  = ren ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(wen) - 2'(ren);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/tsp_back.sv]
// Back end: walks the star slots, runs envelopes, spawns and emits scaled pixels.
`timescale 1ns / 1ps
module tsp_back #(
  parameter int unsigned STAR_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tsp_pkg::cfg_t  cfg_i,
  input  logic           avail_i,
  input  tsp_pkg::work_t work_i,
  output logic           take_o,
  input  logic           res_full_i,
  output logic           res_wr_o,
  output tsp_pkg::res_t  res_o,
  output logic           spawn_o,
  output logic           room_o,
  output logic           idle_o
);
  import tsp_pkg::*;

  localparam int unsigned SlotW = (STAR_SLOTS > 1) ? $clog2(STAR_SLOTS) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(STAR_SLOTS - 1);

  back_state_e state_q, state_d;
  logic [SlotW-1:0] idx_q, idx_d;
  work_t       item_q;
  logic [15:0] gap_elapsed_q, gap_elapsed_d;
  logic [15:0] gap_target_q, gap_target_d;

  logic [STAR_SLOTS-1:0] active_q;
  logic [STAR_SLOTS-1:0] fading_q;
  logic [9:0]  led_q    [STAR_SLOTS];
  logic [15:0] timer_q  [STAR_SLOTS];
  logic [15:0] dur_q    [STAR_SLOTS];
  logic [15:0] level_q  [STAR_SLOTS];
  logic [23:0] colour_q [STAR_SLOTS];

  // Envelope step of the slot under the walk index
  logic [23:0] prod;
  logic [16:0] tsum;
  logic [15:0] tnew;
  logic [24:0] lsum;
  logic [15:0] lclamp;
  logic        upd_en;
  logic        cur_fading;
  logic [15:0] cur_level;

  always_comb begin
    cur_fading = fading_q[idx_q];
    cur_level  = level_q[idx_q];
    prod   = (cur_fading ? cfg_i.fade_out_rate : cfg_i.fade_in_rate) * item_q.tick_ms;
    tsum   = {1'b0, timer_q[idx_q]} + {9'd0, item_q.tick_ms};
    tnew   = tsum[16] ? 16'hFFFF : tsum[15:0];
    lsum   = {9'd0, cur_level} + {1'b0, prod};
    lclamp = (lsum > {9'd0, cfg_i.peak_level}) ? cfg_i.peak_level : lsum[15:0];
    upd_en = (state_q == ST_UPDATE) && active_q[idx_q];
  end

  // Spawn decision: lowest free slot, chance roll or gap timer
  logic [SlotW-1:0] free_idx;
  logic        room;
  logic [16:0] gsum;
  logic [15:0] gel;
  logic [15:0] gtgt;
  logic        spawn_hit;

  always_comb begin
    free_idx = '0;
    for (int i = STAR_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_idx = SlotW'(i);
      end
    end
    room      = ~&active_q;
    gtgt      = (gap_target_q == 16'd0) ? item_q.gap : gap_target_q;
    gsum      = {1'b0, gap_elapsed_q} + {9'd0, item_q.tick_ms};
    gel       = gsum[16] ? 16'hFFFF : gsum[15:0];
    spawn_hit = room && (cfg_i.spawn_mode ? (gel >= gtgt)
                                          : (item_q.chance_roll < cfg_i.chance_permille));
  end

  assign spawn_o = (state_q == ST_SPAWN) && spawn_hit;
  assign room_o  = room;
  assign idle_o  = (state_q == ST_IDLE);

  // Is any slot above the walk index active
  logic more;
  always_comb begin
    more = 1'b0;
    for (int i = 0; i < STAR_SLOTS; i++) begin
      if (SlotW'(i) > idx_q && active_q[i]) begin
        more = 1'b1;
      end
    end
  end

  // Scaled colour of the slot under the walk index
  logic [23:0] pr, pg, pb;
  always_comb begin
    pr = colour_q[idx_q][23:16] * level_q[idx_q];
    pg = colour_q[idx_q][15:8]  * level_q[idx_q];
    pb = colour_q[idx_q][7:0]   * level_q[idx_q];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (avail_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (idx_q == LastSlot) state_d = ST_SPAWN;
      end
      ST_SPAWN: begin
        state_d = ((|active_q) || spawn_hit) ? ST_EMIT : ST_NONE;
      end
      ST_EMIT: begin
        if (idx_q == LastSlot && !(active_q[idx_q] && res_full_i)) state_d = ST_IDLE;
      end
      ST_NONE: begin
        if (!res_full_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and walk index
  always_comb begin
    take_o        = 1'b0;
    res_wr_o      = 1'b0;
    res_o         = '0;
    idx_d         = idx_q;
    gap_elapsed_d = gap_elapsed_q;
    gap_target_d  = gap_target_q;
    case (state_q)
      ST_IDLE: begin
        take_o = avail_i;
        idx_d  = '0;
      end
      ST_UPDATE: begin
        idx_d = (idx_q == LastSlot) ? '0 : idx_q + 1'b1;
      end
      ST_SPAWN: begin
        idx_d = '0;
        if (cfg_i.spawn_mode) begin
          gap_elapsed_d = spawn_hit ? 16'd0 : gel;
          gap_target_d  = spawn_hit ? item_q.gap : gtgt;
        end
      end
      ST_EMIT: begin
        res_o.pixel_valid = 1'b1;
        res_o.led_index   = led_q[idx_q];
        res_o.out_red     = pr[23:16];
        res_o.out_green   = pg[23:16];
        res_o.out_blue    = pb[23:16];
        res_o.last_pixel  = !more;
        res_wr_o          = active_q[idx_q] && !res_full_i;
        if (!(active_q[idx_q] && res_full_i)) begin
          idx_d = (idx_q == LastSlot) ? '0 : idx_q + 1'b1;
        end
      end
      ST_NONE: begin
        res_o.last_pixel = 1'b1;
        res_wr_o         = !res_full_i;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      idx_q         <= '0;
      gap_elapsed_q <= 16'd0;
      gap_target_q  <= 16'd0;
      active_q      <= '0;
      fading_q      <= '0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      gap_elapsed_q <= gap_elapsed_d;
      gap_target_q  <= gap_target_d;
      if (upd_en) begin
        if (!cur_fading) begin
          if (tnew >= dur_q[idx_q]) fading_q[idx_q] <= 1'b1;
        end else if (prod >= {8'd0, cur_level}) begin
          active_q[idx_q] <= 1'b0;
        end
      end
      if (spawn_o) begin
        active_q[free_idx] <= 1'b1;
        fading_q[free_idx] <= 1'b0;
      end
    end
  end

  // Slot payload, tick latch
  always_ff @(posedge clk_i) begin
    if (take_o) item_q <= work_i;
    if (upd_en) begin
      if (!cur_fading) begin
        level_q[idx_q] <= lclamp;
        timer_q[idx_q] <= (tnew >= dur_q[idx_q]) ? 16'd0 : tnew;
      end else begin
        timer_q[idx_q] <= tnew;
        level_q[idx_q] <= (prod >= {8'd0, cur_level}) ? 16'd0 : cur_level - prod[15:0];
      end
    end
    if (spawn_o) begin
      led_q[free_idx]    <= item_q.led;
      timer_q[free_idx]  <= 16'd0;
      dur_q[free_idx]    <= item_q.duration;
      level_q[free_idx]  <= 16'd0;
      colour_q[free_idx] <= item_q.colour;
    end
  end

endmodule

[hw/rtl/twinkle_star_pool_engine.sv]
// Top level of the twinkle star pool engine: config registers, front, back, result queue.
//
// Channel   Direction  Handshake            Payload
// tick      in         push / full          in_item_i (tsp_pkg::in_item_t)
// result    out        empty / pop          res_o     (tsp_pkg::res_t)
// config    in         cfg_valid/cfg_ready  cfg_index_i, cfg_data_i
//
// The slot sequencer runs each tick as a take in idle, one update pass over the slots,
// a spawn step and one emit pass (one empty last result when no star is active or spawned).
// Reset clears slot valid and fading bits, gap timers, queues and restores config.
// Two ticks queue in the front; emit stalls per slot while the result queue is full.
`timescale 1ns / 1ps
module twinkle_star_pool_engine #(
  parameter int unsigned STAR_SLOTS = 16,
  parameter int unsigned LED_COUNT  = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  tsp_pkg::in_item_t                 in_item_i,
  output logic                              empty,
  input  logic                              pop,
  output tsp_pkg::res_t                     res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tsp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [tsp_pkg::CfgDataW-1:0]      cfg_data_i
);
  import tsp_pkg::*;

  cfg_t  cfg_q;
  work_t work;
  res_t  res_w;
  logic  avail, take, res_full, res_wr, spawn, room, idle;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spawn_mode      <= 1'b0;
      cfg_q.chance_permille <= 10'd100;
      cfg_q.peak_level      <= 16'hFFFF;
      cfg_q.fade_in_rate    <= 16'd66;
      cfg_q.fade_out_rate   <= 16'd66;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegSpawnMode:   cfg_q.spawn_mode      <= cfg_data_i[0];
        RegChance:      cfg_q.chance_permille <= cfg_data_i[9:0];
        RegPeakLevel:   cfg_q.peak_level      <= cfg_data_i;
        RegFadeInRate:  cfg_q.fade_in_rate    <= cfg_data_i;
        RegFadeOutRate: cfg_q.fade_out_rate   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tsp_front #(.LED_COUNT(LED_COUNT)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .item_i(in_item_i), .full_o(full),
    .take_i(take), .avail_o(avail), .work_o(work)
  );

  tsp_back #(.STAR_SLOTS(STAR_SLOTS)) u_back (
    .clk_i, .rst_ni,
    .cfg_i(cfg_q), .avail_i(avail), .work_i(work), .take_o(take),
    .res_full_i(res_full), .res_wr_o(res_wr), .res_o(res_w),
    .spawn_o(spawn), .room_o(room), .idle_o(idle)
  );

  tsp_res_fifo u_res (
    .clk_i, .rst_ni,
    .wr_i(res_wr), .data_i(res_w), .full_o(res_full),
    .pop_i(pop), .empty_o(empty), .data_o(res_o)
  );

  // Checks
  a_no_res_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_wr && res_full)) else $error("result written into full queue");
  a_spawn_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spawn |-> room) else $error("spawn without free slot");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (idle && avail)) else $error("tick taken while busy");

endmodule
